// File: src/tpa_pkg.sv
package tpa_pkg;

   localparam int MAX_WORKERS_DEF = 256;
   localparam int CNT_W           = 9;
   localparam int ID_W            = 8;
   localparam int RATIO_W         = 16;
   localparam int PROD_W          = CNT_W + RATIO_W;
   localparam int STATUS_W        = 3;

   localparam logic [1:0] OP_INIT      = 2'd0;
   localparam logic [1:0] OP_TERMINATE = 2'd1;
   localparam logic [1:0] OP_REMOVE    = 2'd2;
   localparam logic [1:0] OP_CREATE    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_INIT  = 3'd4;

   typedef struct packed {
      logic [1:0]      opcode;
      logic            pool_select;
      logic            was_dying;
      logic [ID_W-1:0] returned_id;
   } tpa_req_type;

   typedef struct packed {
      logic [ID_W-1:0]     granted_id;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    running_now;
      logic [CNT_W-1:0]    dying_now;
   } tpa_rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic read;
      logic grant;
      logic mul;
      logic reject;
      logic fill_start;
      logic fill;
      logic finish;
   } tpa_cmd_type;

   typedef struct packed {
      logic is_init;
      logic need_read;
      logic init_reject;
      logic fill_last;
   } tpa_stat_type;

endpackage

// File: src/tpa_ram.sv
module tpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tpa_dp.sv
module tpa_dp #(
   parameter int MAX_WORKERS = tpa_pkg::MAX_WORKERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tpa_pkg::tpa_req_type         req_data,
   input  logic [tpa_pkg::CNT_W-1:0]    total_workers,
   input  logic [tpa_pkg::RATIO_W-1:0]  job_ratio_q16,
   input  tpa_pkg::tpa_cmd_type         cmd,
   output tpa_pkg::tpa_stat_type        stat,
   output tpa_pkg::tpa_rsp_type         rsp_data
);
   import tpa_pkg::*;

   localparam int          ADDR_W    = $clog2(MAX_WORKERS);
   localparam logic [16:0] MAX_LIMIT = 17'(MAX_WORKERS);

   // counters and pool state
   tpa_req_type      item_ff;
   logic [CNT_W-1:0] run_ff  [2];
   logic [CNT_W-1:0] dead_ff [2];
   logic [CNT_W-1:0] gsize_ff;
   logic [CNT_W-1:0] jsize_ff;
   logic             init_done_ff;

   // init sequencing
   logic [PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]  js_ff;
   logic [CNT_W-1:0]  gs_ff;
   logic [CNT_W-1:0]  fill_ff;
   tpa_rsp_type       rsp_ff;

   logic                pool;
   logic [CNT_W-1:0]    run_cur;
   logic [CNT_W-1:0]    dead_cur;
   logic [CNT_W-1:0]    size_cur;
   logic [CNT_W-1:0]    ctr_cur;
   logic [CNT_W-1:0]    run_upd;
   logic [CNT_W-1:0]    dead_upd;
   logic [CNT_W:0]      alive;
   logic [CNT_W:0]      alive_m1;
   logic [CNT_W:0]      addr_cr_w;
   logic [CNT_W:0]      addr_rm_w;
   logic                cr_full;
   logic                rm_full;
   logic [STATUS_W-1:0] exec_status;
   logic                exec_write;
   logic [PROD_W:0]     prod_round;
   logic [CNT_W:0]      js_full;
   logic                init_reject;
   logic                fill_gen;

   logic              gen_wr_en;
   logic              job_wr_en;
   logic [ADDR_W-1:0] gen_wr_addr;
   logic [ADDR_W-1:0] job_wr_addr;
   logic [ID_W-1:0]   wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [ID_W-1:0]   gen_rd_data;
   logic [ID_W-1:0]   job_rd_data;
   logic [ID_W-1:0]   granted;

   always_comb begin
      pool     = item_ff.pool_select;
      run_cur  = run_ff[pool];
      dead_cur = dead_ff[pool];
      size_cur = pool ? jsize_ff : gsize_ff;
      ctr_cur  = item_ff.was_dying ? dead_cur : run_cur;

      alive     = {1'b0, run_cur} + {1'b0, dead_cur};
      alive_m1  = alive - (CNT_W+1)'(1);
      cr_full   = alive >= {1'b0, size_cur};
      rm_full   = alive_m1 >= {1'b0, size_cur};
      addr_cr_w = {1'b0, size_cur} - alive - (CNT_W+1)'(1);
      addr_rm_w = {1'b0, size_cur} - alive_m1 - (CNT_W+1)'(1);

      run_upd     = run_cur;
      dead_upd    = dead_cur;
      exec_status = ST_OK;
      if (!init_done_ff) begin
         exec_status = ST_NOT_INIT;
      end else begin
         case (item_ff.opcode)
            OP_TERMINATE: begin
               if (run_cur == '0) begin
                  exec_status = ST_EMPTY;
               end else begin
                  run_upd  = run_cur - CNT_W'(1);
                  dead_upd = dead_cur + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (ctr_cur == '0) begin
                  exec_status = ST_EMPTY;
               end else if (rm_full) begin
                  exec_status = ST_EXHAUSTED;
               end else if (item_ff.was_dying) begin
                  dead_upd = dead_cur - CNT_W'(1);
               end else begin
                  run_upd = run_cur - CNT_W'(1);
               end
            end
            OP_CREATE: begin
               if (cr_full) begin
                  exec_status = ST_EXHAUSTED;
               end
            end
            default: begin
               exec_status = ST_OK;
            end
         endcase
      end
      exec_write = (item_ff.opcode == OP_REMOVE) && (exec_status == ST_OK);

      // ceil of ratio * total over 2^16
      prod_round  = {1'b0, prod_ff} + (PROD_W+1)'(16'hFFFF);
      js_full     = prod_round[PROD_W -: CNT_W+1];
      init_reject = (total_workers == '0) || (17'(total_workers) > MAX_LIMIT) ||
                    (js_full >= {1'b0, total_workers});

      fill_gen = fill_ff < gs_ff;

      stat.is_init     = item_ff.opcode == OP_INIT;
      stat.need_read   = (item_ff.opcode == OP_CREATE) && (exec_status == ST_OK);
      stat.init_reject = init_reject;
      stat.fill_last   = fill_ff == (total_workers - CNT_W'(1));
   end

   // stack write and read ports
   always_comb begin
      gen_wr_en   = (cmd.exec && exec_write && !pool) || (cmd.fill && fill_gen);
      job_wr_en   = (cmd.exec && exec_write && pool) || (cmd.fill && !fill_gen);
      gen_wr_addr = cmd.fill ? ADDR_W'(fill_ff) : ADDR_W'(addr_rm_w);
      job_wr_addr = cmd.fill ? ADDR_W'(fill_ff - gs_ff) : ADDR_W'(addr_rm_w);
      wr_data     = cmd.fill ? fill_ff[ID_W-1:0] : item_ff.returned_id;
      rd_addr     = ADDR_W'(addr_cr_w);
      granted     = pool ? job_rd_data : gen_rd_data;
   end

   tpa_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_WORKERS)
   ) u_gen_stack (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (gen_rd_data)
   );

   tpa_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_WORKERS)
   ) u_job_stack (
      .clock   (clock),
      .wr_en   (job_wr_en),
      .wr_addr (job_wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (job_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff[0]    <= '0;
         run_ff[1]    <= '0;
         dead_ff[0]   <= '0;
         dead_ff[1]   <= '0;
         gsize_ff     <= '0;
         jsize_ff     <= '0;
         init_done_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            run_ff[pool]  <= run_upd;
            dead_ff[pool] <= dead_upd;
         end
         if (cmd.grant) begin
            run_ff[pool] <= run_cur + CNT_W'(1);
         end
         if (cmd.finish) begin
            gsize_ff     <= gs_ff;
            jsize_ff     <= js_ff;
            init_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(job_ratio_q16) * PROD_W'(total_workers);
      end
      if (cmd.fill_start) begin
         js_ff   <= js_full[CNT_W-1:0];
         gs_ff   <= total_workers - js_full[CNT_W-1:0];
         fill_ff <= '0;
      end else if (cmd.fill) begin
         fill_ff <= fill_ff + CNT_W'(1);
      end
      if (cmd.exec) begin
         rsp_ff <= '{granted_id: '0, status: exec_status,
                     running_now: run_upd, dying_now: dead_upd};
      end else if (cmd.grant) begin
         rsp_ff <= '{granted_id: granted, status: ST_OK,
                     running_now: run_cur + CNT_W'(1), dying_now: dead_cur};
      end else if (cmd.reject) begin
         rsp_ff <= '{granted_id: '0, status: ST_REJECT,
                     running_now: run_cur, dying_now: dead_cur};
      end else if (cmd.finish) begin
         rsp_ff <= '{granted_id: '0, status: ST_OK,
                     running_now: run_cur, dying_now: dead_cur};
      end
   end

   assign rsp_data = rsp_ff;

   a_grant_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> $past(cmd.read))
      else $error("grant without a preceding stack read");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fill |-> (fill_ff < total_workers))
      else $error("fill index beyond total workers");

   a_init_sticky: assert property (@(posedge clock) disable iff (reset)
      init_done_ff |=> init_done_ff)
      else $error("initialized flag dropped");

   a_exec_not_init: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !stat.is_init)
      else $error("init item took the single-step path");

endmodule

// File: src/tpa_ctrl.sv
module tpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tpa_pkg::tpa_stat_type stat,
   output logic                  busy,
   output logic                  rsp_valid,
   output tpa_pkg::tpa_cmd_type  cmd
);
   import tpa_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_FILL  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_init) begin
               cmd.mul  = 1'b1;
               state_in = S_CHECK;
            end else if (stat.need_read) begin
               cmd.read = 1'b1;
               state_in = S_READ;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            cmd.grant = 1'b1;
            state_in  = S_IDLE;
         end
         S_CHECK: begin
            if (stat.init_reject) begin
               cmd.reject = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.fill_start = 1'b1;
               state_in       = S_FILL;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (stat.fill_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.exec || cmd.grant || cmd.reject || cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid_ff)
      else $error("item finished without a result");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result strobe while still working");

endmodule

// File: src/two_pool_worker_id_allocator.sv
// two-pool worker id allocator: hands out unique ids from a general pool and a job pool, each
// kept as a stack of free ids plus running and dying counts. an item is taken when start is
// high and busy is low; its one result shows on rsp_data for exactly one cycle, marked by
// rsp_valid, and the receiver cannot stall it, so it must take the transfer in that cycle.
// terminate, remove, a create that finds its pool exhausted and any item before init pass
// accept, then an update state; a granting create passes accept, a registered read of the
// stack ram, then the grant. init passes accept, a registered multiply, a size check, then
// writes one stack entry per cycle; a rejected init ends after the check.
// busy stays high for the whole item and falls in the cycle the result is shown, so the next
// item can start right then.
// config registers (total_workers at 0x0, job_ratio_q16 at 0x4) are written over the apb-style
// port; the user must write them only while the block is idle, the block does not enforce it.
module two_pool_worker_id_allocator #(
   parameter int MAX_WORKERS = tpa_pkg::MAX_WORKERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   // item channel
   input  logic                 start,
   output logic                 busy,
   input  tpa_pkg::tpa_req_type req_data,

   // result channel, one-cycle strobe
   output logic                 rsp_valid,
   output tpa_pkg::tpa_rsp_type rsp_data,

   // register port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import tpa_pkg::*;

   // register select taken from the word address bit
   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_RATIO = 1'b1;

   logic [CNT_W-1:0]   total_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic               csr_write;
   tpa_cmd_type        cmd;
   tpa_stat_type       stat;

   // register writes complete on the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CNT_W'(1);
         ratio_ff <= '0;
      end else if (csr_write) begin
         case (paddr[2])
            REG_TOTAL: begin
               total_ff <= pwdata[CNT_W-1:0];
            end
            REG_RATIO: begin
               ratio_ff <= pwdata[RATIO_W-1:0];
            end
            default: begin
               total_ff <= total_ff;
            end
         endcase
      end
   end

   // read back, zero filled
   always_comb begin
      case (paddr[2])
         REG_TOTAL: prdata = 32'(total_ff);
         REG_RATIO: prdata = 32'(ratio_ff);
         default:   prdata = '0;
      endcase
   end

   // sequencer: one state per phase of an item
   tpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // counters, stacks, init arithmetic and the result register
   tpa_dp #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .total_workers (total_ff),
      .job_ratio_q16 (ratio_ff),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_data      (rsp_data)
   );

endmodule

// File: verif/tb_two_pool_worker_id_allocator.sv
module tb_two_pool_worker_id_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   import tpa_pkg::*;

   localparam int POOL_LIMIT = MAX_WORKERS_DEF;

   // register byte addresses on the csr port
   localparam logic [2:0] REG_TOTAL = 3'h0;
   localparam logic [2:0] REG_RATIO = 3'h4;

   logic        clock;
   logic        reset;
   logic        start = 1'b0;
   logic        busy;
   tpa_req_type req_data = '0;
   logic        rsp_valid;
   tpa_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   two_pool_worker_id_allocator #(
      .MAX_WORKERS(POOL_LIMIT)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // shadow of the allocator: free-id stacks, sizes and counts per pool
   logic [ID_W-1:0] free_ids [2][POOL_LIMIT];
   int              pool_size [2];
   int              running [2];
   int              dying [2];
   bit              pools_ready;
   int              cfg_total = 1;
   int              cfg_ratio = 0;

   tpa_req_type queued_ops[$];     // ops waiting for the driver
   tpa_rsp_type pool_replies[$];   // predicted replies, oldest first

   int ops_issued;
   int ops_taken;
   int replies_checked;
   int bad_count;
   int status_seen [5];

   // driver burst state
   int burst_left = 1;
   int gap_left;

   task automatic flag_error(input string msg);
      bad_count++;
      if (bad_count <= 10) $display("mismatch: %s", msg);
   endtask

   // advance the shadow by one op and build the reply it should produce
   task automatic model_op(input tpa_req_type op, output tpa_rsp_type reply);
      int     p;
      int     alive;
      int     js;
      int     gs;
      int     slot;
      longint prod;
      p = int'(op.pool_select);
      reply = '0;
      reply.status = ST_OK;
      if (op.opcode == OP_INIT) begin
         // job share rounded up to a whole worker
         prod = longint'(cfg_ratio) * longint'(cfg_total);
         js = int'((prod + 65535) >>> 16);
         if (cfg_total == 0 || cfg_total > POOL_LIMIT || js >= cfg_total) begin
            reply.status = ST_REJECT;
         end else begin
            gs = cfg_total - js;
            for (int i = 0; i < gs; i++) free_ids[0][i] = ID_W'(i);
            for (int i = 0; i < js; i++) free_ids[1][i] = ID_W'(gs + i);
            pool_size[0] = gs;
            pool_size[1] = js;
            pools_ready = 1'b1;
         end
      end else if (!pools_ready) begin
         reply.status = ST_NOT_INIT;
      end else begin
         case (op.opcode)
            OP_TERMINATE: begin
               if (running[p] == 0) begin
                  reply.status = ST_EMPTY;
               end else begin
                  running[p]--;
                  dying[p]++;
               end
            end
            OP_REMOVE: begin
               if ((op.was_dying ? dying[p] : running[p]) == 0) begin
                  reply.status = ST_EMPTY;
               end else begin
                  alive = running[p] + dying[p] - 1;
                  // only after shrinking the pool by a re-init
                  if (alive >= pool_size[p]) begin
                     reply.status = ST_EXHAUSTED;
                  end else begin
                     if (op.was_dying) dying[p]--;
                     else running[p]--;
                     slot = pool_size[p] - alive - 1;
                     free_ids[p][slot] = op.returned_id;
                  end
               end
            end
            default: begin
               alive = running[p] + dying[p];
               if (alive >= pool_size[p]) begin
                  reply.status = ST_EXHAUSTED;
               end else begin
                  slot = pool_size[p] - alive - 1;
                  reply.granted_id = free_ids[p][slot];
                  running[p]++;
               end
            end
         endcase
      end
      reply.running_now = CNT_W'(running[p]);
      reply.dying_now = CNT_W'(dying[p]);
   endtask

   // driver: new op at the falling edge once the previous op has been accepted
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (ops_taken == ops_issued) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_ops.size() > 0) begin
            req_data <= queued_ops.pop_front();
            start <= 1'b1;
            ops_issued++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // next burst, one in three with no gap in front
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check each reply strobe, then record an accepted op
   always @(posedge clock) begin : reply_check
      tpa_rsp_type want;
      tpa_rsp_type fresh;
      if (!reset) begin
         if (rsp_valid) begin
            if (pool_replies.size() == 0) begin
               flag_error($sformatf("reply with nothing pending: id %0d st %0d run %0d dying %0d",
                  rsp_data.granted_id, rsp_data.status, rsp_data.running_now,
                  rsp_data.dying_now));
            end else begin
               want = pool_replies.pop_front();
               replies_checked++;
               if (want.status < 5) status_seen[want.status]++;
               if (rsp_data.granted_id !== want.granted_id || rsp_data.status !== want.status ||
                   rsp_data.running_now !== want.running_now ||
                   rsp_data.dying_now !== want.dying_now) begin
                  flag_error($sformatf({"reply %0d: expected id %0d st %0d run %0d dying %0d,",
                     " got id %0d st %0d run %0d dying %0d"}, replies_checked,
                     want.granted_id, want.status, want.running_now, want.dying_now,
                     rsp_data.granted_id, rsp_data.status, rsp_data.running_now,
                     rsp_data.dying_now));
               end
            end
         end
         if (start && !busy) begin
            model_op(req_data, fresh);
            pool_replies.push_back(fresh);
            ops_taken++;
         end
      end
   end

   task automatic queue_op(input logic [1:0] code, input logic pool, input logic from_dying,
                           input logic [ID_W-1:0] id);
      tpa_req_type it;
      it.opcode = code;
      it.pool_select = pool;
      it.was_dying = from_dying;
      it.returned_id = id;
      queued_ops.push_back(it);
   endtask

   // random ops; create_pct sets how fast the pools fill versus drain
   task automatic queue_random(input int count, input int create_pct);
      tpa_req_type it;
      int          pick;
      repeat (count) begin
         it.pool_select = 1'($urandom_range(0, 1));
         it.was_dying = 1'($urandom_range(0, 1));
         it.returned_id = ID_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 3) it.opcode = OP_INIT;
         else if (pick < 3 + create_pct) it.opcode = OP_CREATE;
         else if (pick < 3 + create_pct + (97 - create_pct) * 35 / 100) it.opcode = OP_TERMINATE;
         else it.opcode = OP_REMOVE;
         queued_ops.push_back(it);
      end
   endtask

   // pause the sender until every transfer has its reply and the block is quiet
   task automatic wait_idle();
      while (queued_ops.size() != 0 || start || ops_taken != ops_issued ||
             pool_replies.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr write followed by a read-back of the same register
   task automatic csr_access(input logic [2:0] addr, input logic [31:0] value,
                             input logic [31:0] mask);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== (value & mask)) begin
         flag_error($sformatf("csr read at 0x%0h: expected 0x%0h, got 0x%0h", addr,
            value & mask, prdata));
      end
      if (pready !== 1'b1) begin
         flag_error($sformatf("csr port at 0x%0h not ready", addr));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input int total, input int ratio);
      wait_idle();
      csr_access(REG_TOTAL, 32'(total), 32'h1FF);
      cfg_total = total & 'h1FF;
      csr_access(REG_RATIO, 32'(ratio), 32'hFFFF);
      cfg_ratio = ratio & 'hFFFF;
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: one worker, no job share
      // every op before init reports not initialized
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_TERMINATE, 1'b1, 1'b0, 8'h00);
      queue_op(OP_REMOVE, 1'b1, 1'b1, 8'hFF);
      queue_op(OP_INIT, 1'b0, 1'b0, 8'h00);
      // job pool is empty, general pool holds a single id
      queue_op(OP_CREATE, 1'b1, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_TERMINATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_TERMINATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_REMOVE, 1'b0, 1'b0, 8'h00);
      // id comes back from the dying count and is granted again
      queue_op(OP_REMOVE, 1'b0, 1'b1, 8'hAA);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);

      // job share rounds up to the whole total: rejected
      set_config(256, 65535);
      queue_op(OP_INIT, 1'b1, 1'b0, 8'h00);
      // total above the pool limit: rejected, old pools stay in use
      set_config(511, 0);
      queue_op(OP_INIT, 1'b0, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      // zero total: rejected
      set_config(0, 1);
      queue_op(OP_INIT, 1'b1, 1'b1, 8'h00);

      // even split of the largest total, counts carried over
      set_config(256, 32768);
      queue_op(OP_INIT, 1'b0, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b1, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_REMOVE, 1'b1, 1'b0, 8'h55);

      // shrink the pools below the live counts
      set_config(4, 16384);
      queue_op(OP_INIT, 1'b0, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_CREATE, 1'b0, 1'b0, 8'h00);
      set_config(2, 0);
      queue_op(OP_INIT, 1'b1, 1'b0, 8'h00);
      queue_op(OP_REMOVE, 1'b0, 1'b0, 8'h01);
      queue_op(OP_TERMINATE, 1'b0, 1'b0, 8'h00);
      queue_op(OP_REMOVE, 1'b0, 1'b1, 8'h02);

      // random phases: fill-leaning first, then drain so the next size fits
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_config($urandom_range(8, 16), $urandom_range(0, 32768));
            1: set_config(256, $urandom_range(0, 65535));
            2: set_config($urandom_range(0, 511), 65535);
            3: set_config($urandom_range(1, 8), 0);
            default: set_config($urandom_range(2, 32), $urandom_range(0, 65535));
         endcase
         queue_op(OP_INIT, 1'($urandom_range(0, 1)), 1'b0, 8'h00);
         queue_random(44, 45);
         queue_random(30, 8);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("covered %0d transfers over init, create, terminate and remove", ops_taken);
      $display("replies ok %0d, rejected %0d, empty %0d, exhausted %0d, uninit %0d",
         status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (bad_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop well past the slowest expected run
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
src/tpa_pkg.sv
src/tpa_ram.sv
src/tpa_dp.sv
src/tpa_ctrl.sv
src/two_pool_worker_id_allocator.sv
verif/tb_two_pool_worker_id_allocator.sv
